/* design/stb_pkg.sv */
// Shared constants and types for the soft timer bank.
package stb_pkg;

	localparam int unsigned TIMERS   = 4;
	localparam int unsigned IdxW     = (TIMERS > 1) ? $clog2(TIMERS) : 1;
	localparam int unsigned FuncW    = 3;
	localparam int unsigned IdW      = 4;
	localparam int unsigned CountW   = 32;
	localparam int unsigned RunW     = 31;
	localparam int unsigned TenthW   = 4;
	localparam logic [RunW-1:0]   RunWrap  = {RunW{1'b1}};
	localparam logic [TenthW-1:0] TenthLen = TenthW'(10);
	localparam logic [CountW-1:0] MinDelay = CountW'(2);

	typedef enum logic [FuncW-1:0] {
		OP_TICK    = 3'd0,
		OP_ONCE    = 3'd1,
		OP_AUTO    = 3'd2,
		OP_STOP    = 3'd3,
		OP_CHECK   = 3'd4,
		OP_RUNTIME = 3'd5,
		OP_DELAY   = 3'd6
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

endpackage

/* design/stb_req_if.sv */
// Request channel of the soft timer bank.
interface stb_req_if;
	logic                          valid;
	logic                          ready;
	logic [stb_pkg::FuncW-1:0]     func;
	logic [stb_pkg::IdW-1:0]       timer_id;
	logic [stb_pkg::CountW-1:0]    period;

	modport source (output valid, func, timer_id, period, input ready);
	modport sink   (input valid, func, timer_id, period, output ready);
endinterface

/* design/stb_rsp_if.sv */
// Result channel of the soft timer bank.
interface stb_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       expired;
	logic [stb_pkg::RunW-1:0]   run_time;
	logic                       delay_done;
	logic                       pulse_10;
	logic                       bad_id;

	modport source (output valid, expired, run_time, delay_done, pulse_10, bad_id, input ready);
	modport sink   (input valid, expired, run_time, delay_done, pulse_10, bad_id, output ready);
endinterface

/* design/soft_timer_bank_core.sv */
// Soft timer bank: a tick walks the timers through one shared decrement unit.
// Start, stop, check, run-time read and delay start finish in the accept cycle;
// their result is registered and valid in the cycle after. A tick first updates
// delay, run time and tenth counter on accept, then walks every timer entry
// through the shared decrement unit. A request is taken only when idle and the
// result register is free or being read. Reset clears all timers, counters and flags.
module soft_timer_bank_core (
	input  logic       clk,
	input  logic       arst_n,
	stb_req_if.sink    req,
	stb_rsp_if.source  rsp
);

	logic [stb_pkg::CountW-1:0] count_q  [stb_pkg::TIMERS];
	logic [stb_pkg::CountW-1:0] count_d  [stb_pkg::TIMERS];
	logic [stb_pkg::CountW-1:0] reload_q [stb_pkg::TIMERS];
	logic [stb_pkg::CountW-1:0] reload_d [stb_pkg::TIMERS];
	logic [stb_pkg::TIMERS-1:0] flag_q, flag_d;
	logic [stb_pkg::TIMERS-1:0] auto_q, auto_d;

	logic [stb_pkg::CountW-1:0] delay_q, delay_d;
	logic                       dflag_q, dflag_d;
	logic [stb_pkg::RunW-1:0]   total_q, total_d;
	logic [stb_pkg::TenthW-1:0] tenth_q, tenth_d;
	logic                       pulse_q, pulse_d;

	stb_pkg::state_t            state_q, state_d;
	logic [stb_pkg::IdxW-1:0]   idx_q, idx_d;

	logic                       out_valid_q, out_valid_d;
	logic                       res_exp_q, res_exp_d;
	logic [stb_pkg::RunW-1:0]   res_run_q, res_run_d;
	logic                       res_dly_q, res_dly_d;
	logic                       res_pls_q, res_pls_d;
	logic                       res_bad_q, res_bad_d;

	logic                       accept;
	logic                       walk_last;
	stb_pkg::op_t               op;
	logic                       id_ok;
	logic [stb_pkg::IdxW-1:0]   id_idx;
	logic [stb_pkg::CountW-1:0] dec_in, dec_out;
	logic [stb_pkg::CountW-1:0] dly_dec;
	logic [stb_pkg::RunW-1:0]   total_inc;
	logic [stb_pkg::TenthW-1:0] tenth_inc;

	assign req.ready = (state_q == stb_pkg::ST_IDLE) && (!out_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign walk_last = (idx_q == stb_pkg::IdxW'(stb_pkg::TIMERS - 1));
	assign op        = stb_pkg::op_t'(req.func);
	assign id_ok     = {1'b0, req.timer_id} < 5'(stb_pkg::TIMERS);
	assign id_idx    = req.timer_id[stb_pkg::IdxW-1:0];

	// shared decrement unit, one timer entry per cycle
	assign dec_in    = count_q[idx_q];
	assign dec_out   = dec_in - stb_pkg::CountW'(1);

	assign dly_dec   = delay_q - stb_pkg::CountW'(1);
	assign total_inc = total_q + stb_pkg::RunW'(1);
	assign tenth_inc = tenth_q + stb_pkg::TenthW'(1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			stb_pkg::ST_IDLE: begin
				if (accept && op == stb_pkg::OP_TICK) begin
					state_d = stb_pkg::ST_WALK;
				end
			end
			stb_pkg::ST_WALK: begin
				if (walk_last) begin
					state_d = stb_pkg::ST_IDLE;
				end
			end
			default: state_d = stb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		count_d     = count_q;
		reload_d    = reload_q;
		flag_d      = flag_q;
		auto_d      = auto_q;
		delay_d     = delay_q;
		dflag_d     = dflag_q;
		total_d     = total_q;
		tenth_d     = tenth_q;
		pulse_d     = pulse_q;
		idx_d       = idx_q;
		out_valid_d = out_valid_q && !rsp.ready;
		res_exp_d   = res_exp_q;
		res_run_d   = res_run_q;
		res_dly_d   = res_dly_q;
		res_pls_d   = res_pls_q;
		res_bad_d   = res_bad_q;

		case (state_q)
			stb_pkg::ST_IDLE: begin
				if (accept) begin
					res_exp_d = 1'b0;
					res_pls_d = 1'b0;
					res_bad_d = 1'b0;
					case (op)
						stb_pkg::OP_TICK: begin
							if (delay_q != '0) begin
								delay_d = dly_dec;
								if (dly_dec == '0) begin
									dflag_d = 1'b1;
								end
							end
							total_d = (total_inc == stb_pkg::RunWrap) ? '0 : total_inc;
							if (tenth_inc >= stb_pkg::TenthLen) begin
								tenth_d = '0;
								pulse_d = 1'b1;
							end else begin
								tenth_d = tenth_inc;
								pulse_d = 1'b0;
							end
							idx_d = '0;
						end
						stb_pkg::OP_ONCE, stb_pkg::OP_AUTO: begin
							if (id_ok) begin
								count_d[id_idx]  = req.period;
								reload_d[id_idx] = req.period;
								flag_d[id_idx]   = 1'b0;
								auto_d[id_idx]   = (op == stb_pkg::OP_AUTO);
							end else begin
								res_bad_d = 1'b1;
							end
						end
						stb_pkg::OP_STOP: begin
							if (id_ok) begin
								count_d[id_idx] = '0;
								flag_d[id_idx]  = 1'b0;
								auto_d[id_idx]  = 1'b0;
							end else begin
								res_bad_d = 1'b1;
							end
						end
						stb_pkg::OP_CHECK: begin
							if (id_ok) begin
								res_exp_d      = flag_q[id_idx];
								flag_d[id_idx] = 1'b0;
							end else begin
								res_bad_d = 1'b1;
							end
						end
						stb_pkg::OP_DELAY: begin
							if (req.period != '0) begin
								delay_d = (req.period == stb_pkg::CountW'(1)) ?
									stb_pkg::MinDelay : req.period;
								dflag_d = 1'b0;
							end
						end
						default: ;
					endcase
					// commands other than tick report at once
					if (op != stb_pkg::OP_TICK) begin
						out_valid_d = 1'b1;
						res_run_d   = total_q;
						res_dly_d   = dflag_d;
					end
				end
			end
			stb_pkg::ST_WALK: begin
				if (dec_in != '0) begin
					if (dec_out == '0) begin
						flag_d[idx_q]  = 1'b1;
						count_d[idx_q] = auto_q[idx_q] ? reload_q[idx_q] : '0;
					end else begin
						count_d[idx_q] = dec_out;
					end
				end
				idx_d = idx_q + stb_pkg::IdxW'(1);
				if (walk_last) begin
					idx_d       = '0;
					out_valid_d = 1'b1;
					res_exp_d   = 1'b0;
					res_bad_d   = 1'b0;
					res_run_d   = total_q;
					res_dly_d   = dflag_q;
					res_pls_d   = pulse_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < stb_pkg::TIMERS; i++) begin
				count_q[i]  <= '0;
				reload_q[i] <= '0;
			end
			flag_q      <= '0;
			auto_q      <= '0;
			delay_q     <= '0;
			dflag_q     <= 1'b0;
			total_q     <= '0;
			tenth_q     <= '0;
			pulse_q     <= 1'b0;
			state_q     <= stb_pkg::ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q     <= count_d;
			reload_q    <= reload_d;
			flag_q      <= flag_d;
			auto_q      <= auto_d;
			delay_q     <= delay_d;
			dflag_q     <= dflag_d;
			total_q     <= total_d;
			tenth_q     <= tenth_d;
			pulse_q     <= pulse_d;
			state_q     <= state_d;
			idx_q       <= idx_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		res_exp_q <= res_exp_d;
		res_run_q <= res_run_d;
		res_dly_q <= res_dly_d;
		res_pls_q <= res_pls_d;
		res_bad_q <= res_bad_d;
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.expired    = res_exp_q;
	assign rsp.run_time   = res_run_q;
	assign rsp.delay_done = res_dly_q;
	assign rsp.pulse_10   = res_pls_q;
	assign rsp.bad_id     = res_bad_q;

endmodule
